// ----- hw/rtl/tfhd_pkg.sv -----
// Shared types, code tables and lookup functions for the token frame text decoder.
`timescale 1ns / 1ps
`default_nettype none

package tfhd_pkg;

	localparam int FRAME_CHARS = 12;
	localparam int NUM_CODES   = 44;
	localparam int FRAME_W     = 72;
	localparam int WIN_W       = 70;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_NO_FLAG    = 3'd1,
		STAT_NO_END     = 3'd2,
		STAT_COMPRESSED = 3'd3,
		STAT_EMPTY      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CHECK,
		ST_SCAN,
		ST_DECODE
	} state_t;

	typedef struct packed {
		logic    frame_shift;
		logic    scan_load;
		logic    scan_step;
		logic    dec_load;
		logic    dec_step;
		logic    pend_load;
		logic    pend_clear;
		logic    emit;
		status_t emit_status;
		logic    emit_last;
	} cmd_t;

	typedef struct packed {
		logic last_char;
		logic data_flag;
		logic comp_flag;
		logic scan_hit;
		logic scan_top;
		logic scan_end;
		logic code_hit;
		logic pend_valid;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] sym;
		logic [3:0] len;
	} code_hit_t;

	localparam logic [7:0] CODE_SYM [NUM_CODES] = '{
		8'h20, 8'h45, 8'h54, 8'h41, 8'h4F, 8'h49, 8'h4E, 8'h53, 8'h48, 8'h52,
		8'h44, 8'h4C, 8'h43, 8'h55, 8'h4D, 8'h57, 8'h46, 8'h47, 8'h59, 8'h50,
		8'h42, 8'h2E, 8'h56, 8'h4B, 8'h2D, 8'h2B, 8'h3F, 8'h21, 8'h22, 8'h58,
		8'h30, 8'h4A, 8'h31, 8'h51, 8'h32, 8'h5A, 8'h33, 8'h35, 8'h34, 8'h39,
		8'h38, 8'h36, 8'h37, 8'h2F
	};

	localparam logic [3:0] CODE_LEN [NUM_CODES] = '{
		4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
		4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
		4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8,
		4'd8, 4'd8, 4'd8, 4'd8
	};

	localparam logic [7:0] CODE_VAL [NUM_CODES] = '{
		8'd1,   8'd4,   8'd13,  8'd3,   8'd31,  8'd28,  8'd23,  8'd20,  8'd3,   8'd0,
		8'd59,  8'd51,  8'd49,  8'd45,  8'd43,  8'd11,  8'd9,   8'd5,   8'd3,   8'd123,
		8'd121, 8'd116, 8'd101, 8'd100, 8'd97,  8'd96,  8'd89,  8'd88,  8'd85,  8'd84,
		8'd21,  8'd20,  8'd17,  8'd16,  8'd9,   8'd8,   8'd5,   8'd4,   8'd245, 8'd244,
		8'd241, 8'd240, 8'd235, 8'd234
	};

	function automatic logic [6:0] alpha_index(input logic [7:0] c);
		logic [6:0] r;
		case (c) inside
			[8'h30:8'h39]: r = 7'(c - 8'h30);
			[8'h41:8'h5A]: r = 7'(c - 8'h41 + 8'd10);
			[8'h61:8'h7A]: r = 7'(c - 8'h61 + 8'd36);
			8'h2D:         r = 7'd62;
			8'h2B:         r = 7'd63;
			8'h2F:         r = 7'd64;
			8'h3F:         r = 7'd65;
			8'h2E:         r = 7'd66;
			default:       r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic code_hit_t code_lookup(input logic [7:0] win, input logic [6:0] rem);
		code_hit_t  r;
		logic [7:0] v;
		r = '0;
		for (int e = NUM_CODES - 1; e >= 0; e--) begin
			v = win >> (4'd8 - CODE_LEN[e]);
			if (({3'b000, CODE_LEN[e]} <= rem) && (v == CODE_VAL[e])) begin
				r.hit = 1'b1;
				r.sym = CODE_SYM[e];
				r.len = CODE_LEN[e];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/token_frame_huffman_text_decoder.sv -----
// Top level of the token frame prefix-code text decoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes 12 token characters, one item per cycle while s_tready is high, packs
// their alphabet indices into a 72-bit frame, then checks the data and
// compression flags, finds the payload end and decodes one character per
// codeword. Input is blocked while a frame is evaluated: a check state, the
// end-zero scan (8 frame bits a cycle), then a decode step per codeword (at
// most 34) and a step to close the frame; these wait while m_tready is low and
// the output register is full. A result item waits in the output register
// while the next frame loads. Errors give one item with a nonzero status,
// character 0 and tlast set.
module token_frame_huffman_text_decoder
	import tfhd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] token_char
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] text_char
	output logic [2:0] m_tuser,   // [2:0] status
	output logic       m_tlast
);

	cmd_t  cmd;
	stat_t stat;

	tfhd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tfhd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_char    (s_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/tfhd_ctrl.sv -----
// Controller state machine: frame load, flag checks, end-zero scan and codeword decode.
`timescale 1ns / 1ps
`default_nettype none

module tfhd_ctrl
	import tfhd_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.emit_status = STAT_OK;
		in_ready        = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.frame_shift = 1'b1;
					if (stat.last_char) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (!stat.data_flag) begin
					if (stat.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = STAT_NO_FLAG;
						cmd.emit_last   = 1'b1;
						state_d         = ST_LOAD;
					end
				end else begin
					cmd.scan_load = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_hit && !stat.scan_top && !stat.comp_flag) begin
					cmd.dec_load = 1'b1;
					state_d      = ST_DECODE;
				end else if (stat.scan_hit || stat.scan_end) begin
					if (stat.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_last   = 1'b1;
						cmd.emit_status = (stat.scan_hit && !stat.scan_top) ?
							STAT_COMPRESSED : STAT_NO_END;
						state_d         = ST_LOAD;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_DECODE: begin
				if (stat.code_hit) begin
					if (!stat.pend_valid || stat.out_free) begin
						cmd.emit      = stat.pend_valid;
						cmd.pend_load = 1'b1;
						cmd.dec_step  = 1'b1;
					end
				end else if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = stat.pend_valid ? STAT_OK : STAT_EMPTY;
					cmd.pend_clear  = 1'b1;
					state_d         = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tfhd_dp.sv -----
// Datapath: frame register, end-zero scanner, codeword window and result register.
`timescale 1ns / 1ps
`default_nettype none

module tfhd_dp
	import tfhd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire  [7:0] in_char,
	input  cmd_t       cmd,
	output stat_t      stat,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_char,
	output logic [2:0] out_status,
	output logic       out_last
);

	logic [FRAME_W-1:0] frame_q;
	logic [FRAME_W-1:0] scan_q;
	logic [WIN_W-1:0]   win_q;
	logic [3:0]         cnt_q;
	logic [3:0]         chunk_q;
	logic [6:0]         rem_q;
	logic [7:0]         pend_q;
	logic               pend_v_q;
	logic               out_v_q;
	logic [7:0]         char_q;
	status_t            status_q;
	logic               last_q;

	logic       zero_hit;
	logic [2:0] zero_ofs;
	logic [6:0] zero_pos;
	code_hit_t  look;
	logic       out_free;

	always_comb begin
		zero_hit = 1'b0;
		zero_ofs = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (!scan_q[k]) begin
				zero_hit = 1'b1;
				zero_ofs = 3'(k);
			end
		end
	end

	assign zero_pos = {chunk_q, zero_ofs};
	assign look     = code_lookup(win_q[WIN_W-1 -: 8], rem_q);
	assign out_free = !out_v_q || out_ready;

	always_comb begin
		stat            = '0;
		stat.last_char  = (cnt_q == 4'(FRAME_CHARS - 1));
		stat.data_flag  = frame_q[FRAME_W-1];
		stat.comp_flag  = frame_q[FRAME_W-2];
		stat.scan_hit   = zero_hit;
		stat.scan_top   = zero_hit && (zero_pos == 7'(FRAME_W - 2));
		stat.scan_end   = (chunk_q == 4'(FRAME_W / 8 - 1));
		stat.code_hit   = look.hit;
		stat.pend_valid = pend_v_q;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_shift) begin
			frame_q <= {frame_q[FRAME_W-7:0], 6'b0} | {65'b0, alpha_index(in_char)};
		end
		if (cmd.scan_load) begin
			scan_q <= {1'b1, frame_q[FRAME_W-2:0]};
		end else if (cmd.scan_step) begin
			scan_q <= {8'hFF, scan_q[FRAME_W-1:8]};
		end
		if (cmd.dec_load) begin
			win_q <= frame_q[WIN_W-1:0];
		end else if (cmd.dec_step) begin
			win_q <= win_q << look.len;
		end
		if (cmd.pend_load) begin
			pend_q <= look.sym;
		end
		if (cmd.emit) begin
			char_q   <= (cmd.emit_status == STAT_OK) ? pend_q : 8'd0;
			status_q <= cmd.emit_status;
			last_q   <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			chunk_q  <= '0;
			rem_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.frame_shift) begin
				cnt_q <= stat.last_char ? 4'd0 : cnt_q + 4'd1;
			end
			if (cmd.scan_load) begin
				chunk_q <= '0;
			end else if (cmd.scan_step) begin
				chunk_q <= chunk_q + 4'd1;
			end
			if (cmd.dec_load) begin
				rem_q <= 7'(WIN_W - 1) - zero_pos;
			end else if (cmd.dec_step) begin
				rem_q <= rem_q - {3'b000, look.len};
			end
			if (cmd.pend_clear) begin
				pend_v_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign out_char   = char_q;
	assign out_status = status_q;
	assign out_last   = last_q;

`ifndef SYNTHESIS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && status_q != STAT_OK |-> last_q)
		else $error("error result without last");
	a_err_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && status_q != STAT_OK |-> char_q == 8'd0)
		else $error("error result with nonzero character");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 7'(WIN_W - 1))
		else $error("payload remainder out of range");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result written over a waiting item");
`endif

endmodule

`default_nettype wire
